>>> sv/srs_pkg.sv
// Shared types and constants for the streaming substring replacement block.
package srs_pkg;

  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;
  localparam int BYTES_W         = 64;
  localparam int LEN_W           = 4;
  localparam int CFG_INDEX_W     = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_BYTES  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_has_byte;
    logic       out_last;
  } out_t;

  typedef struct packed {
    logic [BYTES_W-1:0] bytes;
    logic [LEN_W-1:0]   count;
    logic               has_byte;
    logic               last;
  } batch_t;

endpackage

>>> sv/srs_match.sv
// Pending byte window, pattern compare and result batch for one input byte.
module srs_match #(
  parameter int MaxPattern     = srs_pkg::MAX_PATTERN,
  parameter int MaxReplacement = srs_pkg::MAX_REPLACEMENT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  srs_pkg::in_t                item,
  input  logic                        flush,
  input  logic [srs_pkg::BYTES_W-1:0] pattern_bytes,
  input  logic [srs_pkg::LEN_W-1:0]   pattern_length,
  input  logic [srs_pkg::BYTES_W-1:0] replacement_bytes,
  input  logic [srs_pkg::LEN_W-1:0]   replacement_length,
  output srs_pkg::batch_t             batch
);

  localparam int FillW = $clog2(MaxPattern + 1);
  localparam int IdxW  = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam logic [srs_pkg::LEN_W-1:0] PatMax = srs_pkg::LEN_W'(MaxPattern);
  localparam logic [srs_pkg::LEN_W-1:0] RepMax = srs_pkg::LEN_W'(MaxReplacement);

  logic [7:0]               window [MaxPattern];
  logic [7:0]               window_next [MaxPattern];
  logic [7:0]               merged [MaxPattern];
  logic [FillW-1:0]         fill;
  logic [FillW-1:0]         fill_next;
  logic [FillW-1:0]         slot;
  logic [srs_pkg::LEN_W-1:0] plen;
  logic [srs_pkg::LEN_W-1:0] rlen;
  logic [srs_pkg::LEN_W-1:0] new_fill;
  logic                     compare;
  logic                     match;
  logic [srs_pkg::BYTES_W-1:0] merged_flat;

  always_comb begin
    if (pattern_length == '0) begin
      plen = srs_pkg::LEN_W'(1);
    end else if (pattern_length > PatMax) begin
      plen = PatMax;
    end else begin
      plen = pattern_length;
    end
    rlen = (replacement_length > RepMax) ? RepMax : replacement_length;
  end

  always_comb begin
    slot = (srs_pkg::LEN_W'(fill) >= plen) ? '0 : fill;
    new_fill = srs_pkg::LEN_W'(slot) + srs_pkg::LEN_W'(1);
    compare = (new_fill == plen);
    merged_flat = '0;
    match = 1'b1;
    for (int i = 0; i < MaxPattern; i++) begin
      merged[i] = window[i];
    end
    merged[slot[IdxW-1:0]] = item.in_byte;
    for (int i = 0; i < MaxPattern; i++) begin
      merged_flat[8*i +: 8] = merged[i];
      if ((srs_pkg::LEN_W'(i) < plen) && (merged[i] != pattern_bytes[8*i +: 8])) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    batch.bytes    = merged_flat;
    batch.count    = '0;
    batch.has_byte = 1'b1;
    batch.last     = item.in_last;
    fill_next      = FillW'(new_fill);
    for (int i = 0; i < MaxPattern; i++) begin
      window_next[i] = merged[i];
    end
    if (compare && match) begin
      batch.bytes = replacement_bytes;
      batch.count = rlen;
      fill_next   = '0;
    end else if (compare) begin
      batch.count = item.in_last ? plen : srs_pkg::LEN_W'(1);
      fill_next   = FillW'(plen - srs_pkg::LEN_W'(1));
      for (int i = 0; i < MaxPattern - 1; i++) begin
        window_next[i] = merged[i+1];
      end
    end else if (item.in_last) begin
      batch.count = new_fill;
    end
    if (item.in_last) begin
      fill_next = '0;
      if (batch.count == '0) begin
        batch.bytes    = '0;
        batch.count    = srs_pkg::LEN_W'(1);
        batch.has_byte = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      fill <= '0;
    end else if (take) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < MaxPattern; i++) begin
        window[i] <= window_next[i];
      end
    end
  end

endmodule

>>> sv/substring_replace_stream.sv
// Top level of the streaming substring find-and-replace block.
// Each accepted source byte is resolved in the same cycle against the pending
// window, and the result bytes it releases are loaded into the output register,
// which sends one result transaction per cycle while dst_stall is low. A new
// source byte is held off until the last result of the previous byte is being
// sent; a byte that releases several results (a replacement, or the flush of the
// window on the last byte) thus holds the channel, since the output register holds
// one batch. Configuration writes are always ready and should be made between
// strings; writing the pattern length drops any pending window bytes.
module substring_replace_stream #(
  parameter int MaxPattern     = srs_pkg::MAX_PATTERN,
  parameter int MaxReplacement = srs_pkg::MAX_REPLACEMENT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            src_valid,
  output logic                            src_stall,
  input  srs_pkg::in_t                    src_data,
  output logic                            dst_valid,
  input  logic                            dst_stall,
  output srs_pkg::out_t                   dst_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [srs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [srs_pkg::BYTES_W-1:0]     cfg_data
);

  logic [srs_pkg::BYTES_W-1:0] pattern_bytes;
  logic [srs_pkg::LEN_W-1:0]   pattern_length;
  logic [srs_pkg::BYTES_W-1:0] replacement_bytes;
  logic [srs_pkg::LEN_W-1:0]   replacement_length;

  logic [srs_pkg::BYTES_W-1:0] res_bytes;
  logic [srs_pkg::LEN_W-1:0]   res_count;
  logic                        res_has_byte;
  logic                        res_last;

  srs_pkg::batch_t batch;
  logic            cfg_write;
  logic            flush;
  logic            take_in;
  logic            take_out;
  logic            free;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign flush     = cfg_write && (cfg_index == srs_pkg::REG_PATTERN_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= srs_pkg::LEN_W'(1);
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        srs_pkg::REG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
        srs_pkg::REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[srs_pkg::LEN_W-1:0];
        srs_pkg::REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
        srs_pkg::REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[srs_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign dst_valid = (res_count != '0);
  assign take_out  = dst_valid && !dst_stall;
  assign free      = (res_count == '0) || ((res_count == srs_pkg::LEN_W'(1)) && take_out);
  assign src_stall = !free;
  assign take_in   = src_valid && free;

  assign dst_data.out_byte     = res_bytes[7:0];
  assign dst_data.out_has_byte = res_has_byte;
  assign dst_data.out_last     = res_last && (res_count == srs_pkg::LEN_W'(1));

  srs_match #(
    .MaxPattern     (MaxPattern),
    .MaxReplacement (MaxReplacement)
  ) u_match (
    .clk                (clk),
    .rst                (rst),
    .take               (take_in),
    .item               (src_data),
    .flush              (flush),
    .pattern_bytes      (pattern_bytes),
    .pattern_length     (pattern_length),
    .replacement_bytes  (replacement_bytes),
    .replacement_length (replacement_length),
    .batch              (batch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_count <= '0;
    end else if (take_in) begin
      res_count <= batch.count;
    end else if (take_out) begin
      res_count <= res_count - srs_pkg::LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      res_bytes    <= batch.bytes;
      res_has_byte <= batch.has_byte;
      res_last     <= batch.last;
    end else if (take_out) begin
      res_bytes <= {8'd0, res_bytes[srs_pkg::BYTES_W-1:8]};
    end
  end

endmodule
